@@ hdl/lmpm_pkg.sv @@
// Shared types, codes and the neighbor offset table of the particle mover.
`timescale 1ns / 1ps
package lmpm_pkg;

	localparam int SIZE_X_DEF        = 32;
	localparam int SIZE_Y_DEF        = 32;
	localparam int SIZE_Z_DEF        = 32;
	localparam int MAX_PARTICLES_DEF = 4096;

	localparam int NB_COUNT = 12;

	// result status codes
	localparam logic [2:0] STAT_PLACED   = 3'd0;
	localparam logic [2:0] STAT_BLOCKED  = 3'd1;
	localparam logic [2:0] STAT_FULL     = 3'd2;
	localparam logic [2:0] STAT_BAD_IDX  = 3'd3;
	localparam logic [2:0] STAT_BOUNDS   = 3'd4;
	localparam logic [2:0] STAT_OCCUPIED = 3'd5;
	localparam logic [2:0] STAT_REJECTED = 3'd6;
	localparam logic [2:0] STAT_MOVED    = 3'd7;

	// configuration register indexes
	localparam logic [2:0] CFG_EE  = 3'd0;
	localparam logic [2:0] CFG_EF  = 3'd1;
	localparam logic [2:0] CFG_FE  = 3'd2;
	localparam logic [2:0] CFG_FF  = 3'd3;
	localparam logic [2:0] CFG_SUB = 3'd4;

	localparam logic OP_DROP = 1'b0;
	localparam logic OP_MOVE = 1'b1;

	typedef enum logic [3:0] {
		SQ_CLEAR,
		SQ_IDLE,
		SQ_WRAP,
		SQ_DROP_CHK,
		SQ_DROP_EVAL,
		SQ_FALL_RD,
		SQ_FALL_CHK,
		SQ_DROP_WR,
		SQ_MV_CHK,
		SQ_MV_POS,
		SQ_MV_TGT,
		SQ_MV_NB,
		SQ_MV_DEC,
		SQ_OUT
	} state_t;

	// neighbor offsets, indexed [layer parity][direction]
	localparam logic signed [1:0] NB_DX [2][NB_COUNT] = '{
		'{2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1},
		'{2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd0, 2'sd0}
	};
	localparam logic signed [1:0] NB_DY [2][NB_COUNT] = '{
		'{2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd1},
		'{2'sd0, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd0, -2'sd1, 2'sd0, -2'sd1, 2'sd0, -2'sd1, 2'sd0}
	};
	localparam logic signed [1:0] NB_DZ [2][NB_COUNT] = '{
		'{2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1, -2'sd1, -2'sd1},
		'{2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1, -2'sd1, -2'sd1}
	};

endpackage

@@ hdl/lmpm_nb_gen.sv @@
// Neighbor coordinate unit: applies one offset with x/y wrap and z range flags.
`timescale 1ns / 1ps
module lmpm_nb_gen #(
	parameter int SIZE_X = lmpm_pkg::SIZE_X_DEF,
	parameter int SIZE_Y = lmpm_pkg::SIZE_Y_DEF,
	parameter int SIZE_Z = lmpm_pkg::SIZE_Z_DEF,
	localparam int XW = $clog2(SIZE_X),
	localparam int YW = $clog2(SIZE_Y),
	localparam int ZW = $clog2(SIZE_Z)
) (
	input  logic [XW-1:0] bx,
	input  logic [YW-1:0] by,
	input  logic [ZW-1:0] bz,
	input  logic          par,
	input  logic [3:0]    dir,
	output logic [XW-1:0] nx,
	output logic [YW-1:0] ny,
	output logic [ZW-1:0] nz,
	output logic          z_in,
	output logic          z_zero
);

	logic signed [1:0]    dx, dy, dz;
	logic signed [ZW+1:0] zr;

	assign dx = lmpm_pkg::NB_DX[par][dir];
	assign dy = lmpm_pkg::NB_DY[par][dir];
	assign dz = lmpm_pkg::NB_DZ[par][dir];

	always_comb begin
		case (dx)
			2'sd1:   nx = (bx == XW'(SIZE_X - 1)) ? '0 : bx + XW'(1);
			-2'sd1:  nx = (bx == '0) ? XW'(SIZE_X - 1) : bx - XW'(1);
			default: nx = bx;
		endcase
		case (dy)
			2'sd1:   ny = (by == YW'(SIZE_Y - 1)) ? '0 : by + YW'(1);
			-2'sd1:  ny = (by == '0) ? YW'(SIZE_Y - 1) : by - YW'(1);
			default: ny = by;
		endcase
	end

	assign zr     = $signed({2'b00, bz}) + (ZW+2)'(dz);
	assign z_in   = (zr >= 0) && (zr < $signed((ZW+2)'(SIZE_Z)));
	assign z_zero = (zr == 0);
	assign nz     = zr[ZW-1:0];

endmodule

@@ hdl/lattice_metropolis_particle_mover.sv @@
// Top level: lattice-gas particle mover with Metropolis move acceptance.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready| tuser: operation; tdata: x, y, index,
//          |     |                  |   direction, threshold
//  m_*     | out | m_tvalid/m_tready| tuser: status; tdata: site x/y/z,
//          |     |                  |   energy change, particle count
//  cfg_*   | in  | cfg_valid/ready  | cfg_index, cfg_data (always ready)
//
// One request at a time. A drop first folds the column into the lattice,
// then walks down the column one layer at a time. A move reads the 24
// neighbors of head and tail through the single read port of the site memory.
// After reset, the block sweeps the site memory to empty; s_tready stays low
// until the sweep ends.
// A finished result holds in m_tdata/m_tuser until m_tready takes it.
`timescale 1ns / 1ps
module lattice_metropolis_particle_mover #(
	parameter int SIZE_X        = lmpm_pkg::SIZE_X_DEF,
	parameter int SIZE_Y        = lmpm_pkg::SIZE_Y_DEF,
	parameter int SIZE_Z        = lmpm_pkg::SIZE_Z_DEF,
	parameter int MAX_PARTICLES = lmpm_pkg::MAX_PARTICLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [4:0] column_x, [9:5] column_y, [21:10] particle_index,
	// [25:22] move_direction, [48:26] accept_threshold, rest zero
	input  logic [55:0] s_tdata,
	// [0] operation
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [4:0] site_x, [9:5] site_y, [14:10] site_z, [37:15] energy_change,
	// [50:38] particle_count, rest zero
	output logic [55:0] m_tdata,
	// [2:0] status
	output logic [2:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int XW = $clog2(SIZE_X);
	localparam int YW = $clog2(SIZE_Y);
	localparam int ZW = $clog2(SIZE_Z);
	localparam int AW = XW + YW + ZW;
	localparam int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int NB_LAST = 2 * lmpm_pkg::NB_COUNT;

	typedef struct packed {
		logic valid;
		logic head;
		logic zin;
		logic zzero;
	} tag_t;

	lmpm_pkg::state_t state_q, state_nx;

	// configuration registers
	logic [15:0] e_q [5];

	// request capture
	logic [4:0]         cx_q, cy_q;
	logic [11:0]        p_q;
	logic [3:0]         dir_q;
	logic signed [22:0] thr_q;

	// working position and result
	logic [XW-1:0]      x_q, hx_q;
	logic [YW-1:0]      y_q, hy_q;
	logic [ZW-1:0]      z_q, hz_q;
	logic               par_q;
	logic [2:0]         status_q;
	logic signed [22:0] de_q;
	logic signed [16:0] d0_q, d1_q;
	logic [4:0]         nb_q;
	tag_t               tag_s1;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      clr_q;

	// memories
	logic                site_mem [2**AW];
	logic [AW-1:0]       pos_mem [MAX_PARTICLES];
	logic                site_rd_q;
	logic [AW-1:0]       pos_rd_q;
	logic                site_we, pos_we;
	logic [AW-1:0]       site_wa, site_ra, pos_wd;
	logic                site_wd;
	logic [PW-1:0]       pos_wa, pos_ra;

	// shared neighbor unit
	logic [XW-1:0] g_bx, g_nx;
	logic [YW-1:0] g_by, g_ny;
	logic [ZW-1:0] g_bz, g_nz;
	logic          g_par, g_zin, g_zzero;
	logic [3:0]    g_dir;

	logic s_acc, nb_head, occ_now, accept_mv, idx_bad, full;
	logic signed [22:0] term, sub_term;
	logic [XW-1:0] px;
	logic [YW-1:0] py;
	logic [ZW-1:0] pz;

	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign {px, py, pz} = pos_rd_q;
	assign nb_head   = (nb_q < 5'(lmpm_pkg::NB_COUNT));
	assign idx_bad   = (int'(p_q) >= int'(count_q)) || (int'(dir_q) >= lmpm_pkg::NB_COUNT);
	assign full      = (int'(count_q) >= MAX_PARTICLES);
	assign accept_mv = (de_q > 0) || (de_q > thr_q);

	lmpm_nb_gen #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_nb (
		.bx(g_bx), .by(g_by), .bz(g_bz), .par(g_par), .dir(g_dir),
		.nx(g_nx), .ny(g_ny), .nz(g_nz), .z_in(g_zin), .z_zero(g_zzero)
	);

	// unit inputs: the moving particle's own step, or a head/tail neighbor
	always_comb begin
		if (state_q == lmpm_pkg::SQ_MV_POS) begin
			g_bx = px; g_by = py; g_bz = pz; g_par = pz[0]; g_dir = dir_q;
		end else if (nb_head) begin
			g_bx = hx_q; g_by = hy_q; g_bz = hz_q; g_par = par_q; g_dir = nb_q[3:0];
		end else begin
			g_bx = x_q; g_by = y_q; g_bz = z_q; g_par = par_q;
			g_dir = 4'(nb_q - 5'(lmpm_pkg::NB_COUNT));
		end
	end

	// one neighbor's contribution to dE
	always_comb begin
		logic signed [16:0] d;
		occ_now  = tag_s1.zin && site_rd_q;
		d        = occ_now ? d1_q : d0_q;
		term     = tag_s1.head ? 23'(d) : -23'(d);
		sub_term = tag_s1.zzero ? (tag_s1.head ? 23'($signed(e_q[lmpm_pkg::CFG_SUB]))
			: -23'($signed(e_q[lmpm_pkg::CFG_SUB]))) : '0;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lmpm_pkg::SQ_CLEAR:     if (&clr_q) state_nx = lmpm_pkg::SQ_IDLE;
			lmpm_pkg::SQ_IDLE:      if (s_acc) state_nx = (s_tuser == lmpm_pkg::OP_MOVE)
				? lmpm_pkg::SQ_MV_CHK : lmpm_pkg::SQ_WRAP;
			lmpm_pkg::SQ_WRAP: begin
				if (int'(cx_q) < SIZE_X && int'(cy_q) < SIZE_Y)
					state_nx = lmpm_pkg::SQ_DROP_CHK;
			end
			lmpm_pkg::SQ_DROP_CHK:  state_nx = full ? lmpm_pkg::SQ_OUT : lmpm_pkg::SQ_DROP_EVAL;
			lmpm_pkg::SQ_DROP_EVAL: state_nx = site_rd_q ? lmpm_pkg::SQ_OUT : lmpm_pkg::SQ_FALL_RD;
			lmpm_pkg::SQ_FALL_RD:   state_nx = (z_q == '0) ? lmpm_pkg::SQ_DROP_WR
				: lmpm_pkg::SQ_FALL_CHK;
			lmpm_pkg::SQ_FALL_CHK:  state_nx = site_rd_q ? lmpm_pkg::SQ_DROP_WR
				: lmpm_pkg::SQ_FALL_RD;
			lmpm_pkg::SQ_DROP_WR:   state_nx = lmpm_pkg::SQ_OUT;
			lmpm_pkg::SQ_MV_CHK:    state_nx = idx_bad ? lmpm_pkg::SQ_OUT : lmpm_pkg::SQ_MV_POS;
			lmpm_pkg::SQ_MV_POS:    state_nx = (g_zin && !g_zzero) ? lmpm_pkg::SQ_MV_TGT
				: lmpm_pkg::SQ_OUT;
			lmpm_pkg::SQ_MV_TGT:    state_nx = site_rd_q ? lmpm_pkg::SQ_OUT : lmpm_pkg::SQ_MV_NB;
			lmpm_pkg::SQ_MV_NB:     if (nb_q == 5'(NB_LAST)) state_nx = lmpm_pkg::SQ_MV_DEC;
			lmpm_pkg::SQ_MV_DEC:    state_nx = lmpm_pkg::SQ_OUT;
			lmpm_pkg::SQ_OUT:       if (m_tready) state_nx = lmpm_pkg::SQ_IDLE;
			default:                state_nx = lmpm_pkg::SQ_IDLE;
		endcase
	end

	// memory ports and handshake outputs
	always_comb begin
		site_we  = 1'b0;
		site_wa  = {x_q, y_q, z_q};
		site_wd  = 1'b0;
		site_ra  = {x_q, y_q, z_q};
		pos_we   = 1'b0;
		pos_wa   = PW'(count_q);
		pos_wd   = {x_q, y_q, z_q};
		pos_ra   = PW'(p_q);
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			lmpm_pkg::SQ_CLEAR: begin
				site_we = 1'b1;
				site_wa = clr_q;
			end
			lmpm_pkg::SQ_IDLE:      s_tready = 1'b1;
			lmpm_pkg::SQ_DROP_CHK:  site_ra = {XW'(cx_q), YW'(cy_q), ZW'(SIZE_Z - 2)};
			lmpm_pkg::SQ_FALL_RD:   site_ra = {x_q, y_q, z_q - ZW'(1)};
			lmpm_pkg::SQ_DROP_WR: begin
				site_we = 1'b1;
				site_wd = 1'b1;
				pos_we  = 1'b1;
			end
			lmpm_pkg::SQ_MV_POS:    site_ra = {g_nx, g_ny, g_nz};
			lmpm_pkg::SQ_MV_TGT:    site_we = !site_rd_q;
			lmpm_pkg::SQ_MV_NB:     site_ra = {g_nx, g_ny, g_nz};
			lmpm_pkg::SQ_MV_DEC: begin
				site_we = 1'b1;
				site_wd = 1'b1;
				if (accept_mv) begin
					site_wa = {hx_q, hy_q, hz_q};
					pos_we  = 1'b1;
					pos_wa  = PW'(p_q);
					pos_wd  = {hx_q, hy_q, hz_q};
				end
			end
			lmpm_pkg::SQ_OUT:       m_tvalid = 1'b1;
			default: ;
		endcase
	end

	// site and position memories
	always_ff @(posedge clk) begin
		if (site_we) site_mem[site_wa] <= site_wd;
		site_rd_q <= site_mem[site_ra];
		if (pos_we) pos_mem[pos_wa] <= pos_wd;
		pos_rd_q <= pos_mem[pos_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmpm_pkg::SQ_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			for (int i = 0; i < 5; i++) e_q[i] <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == lmpm_pkg::SQ_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == lmpm_pkg::SQ_DROP_WR) count_q <= count_q + CW'(1);
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					lmpm_pkg::CFG_EE:  e_q[0] <= cfg_data;
					lmpm_pkg::CFG_EF:  e_q[1] <= cfg_data;
					lmpm_pkg::CFG_FE:  e_q[2] <= cfg_data;
					lmpm_pkg::CFG_FF:  e_q[3] <= cfg_data;
					lmpm_pkg::CFG_SUB: e_q[4] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lmpm_pkg::SQ_IDLE: begin
				cx_q   <= s_tdata[4:0];
				cy_q   <= s_tdata[9:5];
				p_q    <= s_tdata[21:10];
				dir_q  <= s_tdata[25:22];
				thr_q  <= $signed(s_tdata[48:26]);
				de_q   <= '0;
				tag_s1 <= '0;
			end
			lmpm_pkg::SQ_WRAP: begin
				// fold the column into the lattice one subtraction a cycle
				if (int'(cx_q) >= SIZE_X) cx_q <= cx_q - 5'(SIZE_X);
				else if (int'(cy_q) >= SIZE_Y) cy_q <= cy_q - 5'(SIZE_Y);
			end
			lmpm_pkg::SQ_DROP_CHK: begin
				x_q      <= XW'(cx_q);
				y_q      <= YW'(cy_q);
				z_q      <= ZW'(SIZE_Z - 2);
				status_q <= lmpm_pkg::STAT_FULL;
			end
			lmpm_pkg::SQ_DROP_EVAL: status_q <= lmpm_pkg::STAT_BLOCKED;
			lmpm_pkg::SQ_FALL_RD: begin
				if (z_q == '0) z_q <= ZW'(1);
				else z_q <= z_q - ZW'(1);
			end
			lmpm_pkg::SQ_FALL_CHK:  if (site_rd_q) z_q <= z_q + ZW'(1);
			lmpm_pkg::SQ_DROP_WR:   status_q <= lmpm_pkg::STAT_PLACED;
			lmpm_pkg::SQ_MV_CHK: begin
				x_q      <= '0;
				y_q      <= '0;
				z_q      <= '0;
				status_q <= lmpm_pkg::STAT_BAD_IDX;
			end
			lmpm_pkg::SQ_MV_POS: begin
				x_q      <= px;
				y_q      <= py;
				z_q      <= pz;
				par_q    <= pz[0];
				hx_q     <= g_nx;
				hy_q     <= g_ny;
				hz_q     <= g_nz;
				status_q <= lmpm_pkg::STAT_BOUNDS;
			end
			lmpm_pkg::SQ_MV_TGT: begin
				status_q <= lmpm_pkg::STAT_OCCUPIED;
				d0_q <= $signed({e_q[2][15], e_q[2]}) - $signed({e_q[0][15], e_q[0]});
				d1_q <= $signed({e_q[3][15], e_q[3]}) - $signed({e_q[1][15], e_q[1]});
				nb_q <= '0;
			end
			lmpm_pkg::SQ_MV_NB: begin
				// issue one neighbor read, fold in the previous one
				tag_s1.valid <= (nb_q != 5'(NB_LAST));
				tag_s1.head  <= nb_head;
				tag_s1.zin   <= g_zin;
				tag_s1.zzero <= g_zzero;
				if (tag_s1.valid) de_q <= de_q + term + sub_term;
				nb_q <= nb_q + 5'd1;
			end
			lmpm_pkg::SQ_MV_DEC: begin
				if (accept_mv) begin
					x_q      <= hx_q;
					y_q      <= hy_q;
					z_q      <= hz_q;
					status_q <= lmpm_pkg::STAT_MOVED;
				end else begin
					status_q <= lmpm_pkg::STAT_REJECTED;
				end
			end
			default: ;
		endcase
	end

	assign m_tuser = status_q;
	assign m_tdata = {5'b0, 13'(count_q), de_q, 5'(z_q), 5'(y_q), 5'(x_q)};

endmodule

@@ hdl/lmpm_checker.sv @@
// Port-level checks on the particle mover, bound to the top level.
`timescale 1ns / 1ps
module lmpm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [2:0]  m_tuser
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !m_tvalid)
		else $error("result shown in the cycle after accept");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	a_energy_only_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != lmpm_pkg::STAT_REJECTED && m_tuser != lmpm_pkg::STAT_MOVED)
		|-> (m_tdata[37:15] == 23'd0))
		else $error("energy change on a result without a tried move");

endmodule

bind lattice_metropolis_particle_mover lmpm_checker u_lmpm_checker (.*);

@@ sim/lmpm_result_checker.sv @@
// Result checker: predicts every particle-mover result and compares it with the output.
`timescale 1ns / 1ps
module lmpm_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          placed
);

	typedef struct {
		logic [2:0]         status;
		logic [4:0]         x, y, z;
		logic signed [22:0] de;
		logic [12:0]        count;
	} mover_result_t;

	localparam int DX [2][12] = '{
		'{1, -1, 0, 0, 0, 0, 1, 1, 0, 0, 1, 1},
		'{1, -1, 0, 0, -1, -1, 0, 0, -1, -1, 0, 0}};
	localparam int DY [2][12] = '{
		'{0, 0, 1, -1, 0, 1, 0, 1, 0, 1, 0, 1},
		'{0, 0, 1, -1, -1, 0, -1, 0, -1, 0, -1, 0}};
	localparam int DZ [12] = '{0, 0, 0, 0, 1, 1, 1, 1, -1, -1, -1, -1};

	int            site_owner [32768];
	logic [4:0]    pos_x [4096], pos_y [4096], pos_z [4096];
	int            particle_total;
	int            pair_e [2][2];
	int            sub_e;
	mover_result_t expected_results [$];

	assign pending = expected_results.size();
	assign placed  = particle_total;

	function automatic int site_at(input int x, input int y, input int z);
		return ((x & 31) << 10) | ((y & 31) << 5) | z;
	endfunction

	function automatic int occupied(input int x, input int y, input int z);
		if (z < 0 || z >= lmpm_pkg::SIZE_Z_DEF)
			return 0;
		return int'(site_owner[site_at(x, y, z)] != 0);
	endfunction

	// Work out the result of one request and update the lattice copy.
	task automatic predict_step(input logic op, input logic [55:0] d);
		mover_result_t r;
		int x, y, z, p, dir, par, hx, hy, hz, mh, mt, de, thr;
		r = '{default: '0};
		r.status = lmpm_pkg::STAT_PLACED;
		if (op == lmpm_pkg::OP_DROP) begin
			x = int'(d[4:0]);
			y = int'(d[9:5]);
			z = lmpm_pkg::SIZE_Z_DEF - 2;
			if (particle_total >= lmpm_pkg::MAX_PARTICLES_DEF) begin
				r.status = lmpm_pkg::STAT_FULL;
			end else if (site_owner[site_at(x, y, z)] != 0) begin
				r.status = lmpm_pkg::STAT_BLOCKED;
			end else begin
				while (z > 0 && site_owner[site_at(x, y, z)] == 0)
					z--;
				z++;
				pos_x[particle_total] = 5'(x);
				pos_y[particle_total] = 5'(y);
				pos_z[particle_total] = 5'(z);
				site_owner[site_at(x, y, z)] = particle_total + 1;
				particle_total++;
			end
			r.x = 5'(x);
			r.y = 5'(y);
			r.z = 5'(z);
		end else begin
			p   = int'(d[21:10]);
			dir = int'(d[25:22]);
			thr = int'($signed(d[48:26]));
			de  = 0;
			if (p >= particle_total || dir >= lmpm_pkg::NB_COUNT) begin
				r.status = lmpm_pkg::STAT_BAD_IDX;
			end else begin
				x = int'(pos_x[p]);
				y = int'(pos_y[p]);
				z = int'(pos_z[p]);
				par = z & 1;
				hx = (x + DX[par][dir]) & 31;
				hy = (y + DY[par][dir]) & 31;
				hz = z + DZ[dir];
				r.x = 5'(x);
				r.y = 5'(y);
				r.z = 5'(z);
				if (hz <= 0 || hz >= lmpm_pkg::SIZE_Z_DEF) begin
					r.status = lmpm_pkg::STAT_BOUNDS;
				end else if (site_owner[site_at(hx, hy, hz)] != 0) begin
					r.status = lmpm_pkg::STAT_OCCUPIED;
				end else begin
					// vacate the tail before sampling both neighborhoods
					site_owner[site_at(x, y, z)] = 0;
					for (int i = 0; i < lmpm_pkg::NB_COUNT; i++) begin
						mh = occupied(hx + DX[par][i], hy + DY[par][i], hz + DZ[i]);
						mt = occupied(x + DX[par][i], y + DY[par][i], z + DZ[i]);
						de += pair_e[1][mh] - pair_e[0][mh];
						de += pair_e[0][mt] - pair_e[1][mt];
						if (z + DZ[i] == 0)
							de -= sub_e;
						if (hz + DZ[i] == 0)
							de += sub_e;
					end
					if (de > 0 || de > thr) begin
						site_owner[site_at(hx, hy, hz)] = p + 1;
						pos_x[p] = 5'(hx);
						pos_y[p] = 5'(hy);
						pos_z[p] = 5'(hz);
						r.status = lmpm_pkg::STAT_MOVED;
						r.x = 5'(hx);
						r.y = 5'(hy);
						r.z = 5'(hz);
					end else begin
						site_owner[site_at(x, y, z)] = p + 1;
						r.status = lmpm_pkg::STAT_REJECTED;
					end
					r.de = de[22:0];
				end
			end
		end
		r.count = particle_total[12:0];
		expected_results.push_back(r);
	endtask

	task automatic compare_result();
		mover_result_t e;
		if (expected_results.size() == 0) begin
			$error("result with nothing expected: status %0d", m_tuser);
			fail_count++;
			return;
		end
		e = expected_results.pop_front();
		if (m_tuser !== e.status) begin
			$error("status expected %0d actual %0d", e.status, m_tuser);
			fail_count++;
		end
		if (m_tdata[4:0] !== e.x) begin
			$error("site_x expected %0d actual %0d", e.x, m_tdata[4:0]);
			fail_count++;
		end
		if (m_tdata[9:5] !== e.y) begin
			$error("site_y expected %0d actual %0d", e.y, m_tdata[9:5]);
			fail_count++;
		end
		if (m_tdata[14:10] !== e.z) begin
			$error("site_z expected %0d actual %0d", e.z, m_tdata[14:10]);
			fail_count++;
		end
		if (m_tdata[37:15] !== e.de) begin
			$error("energy_change expected %0d actual %0d", e.de,
				$signed(m_tdata[37:15]));
			fail_count++;
		end
		if (m_tdata[50:38] !== e.count) begin
			$error("particle_count expected %0d actual %0d", e.count, m_tdata[50:38]);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		particle_total = 0;
		pair_e = '{'{0, 0}, '{0, 0}};
		sub_e = 0;
		foreach (site_owner[i])
			site_owner[i] = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				compare_result();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lmpm_pkg::CFG_EE:  pair_e[0][0] = int'($signed(cfg_data));
					lmpm_pkg::CFG_EF:  pair_e[0][1] = int'($signed(cfg_data));
					lmpm_pkg::CFG_FE:  pair_e[1][0] = int'($signed(cfg_data));
					lmpm_pkg::CFG_FF:  pair_e[1][1] = int'($signed(cfg_data));
					lmpm_pkg::CFG_SUB: sub_e = int'($signed(cfg_data));
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_step(s_tuser, s_tdata);
		end
	end

endmodule

@@ sim/lattice_metropolis_particle_mover_tb.sv @@
// Testbench top: stimulus, flow control and verdict for the lattice particle mover.
`timescale 1ns / 1ps
module lattice_metropolis_particle_mover_tb;

	// no-progress limit: covers the site memory sweep after reset
	// plus the longest receiver hold-off, several times over
	localparam int STALL_LIMIT = 200000;
	localparam int HOLD_CYCLES = 600;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;  // [4:0] x, [9:5] y, [21:10] index, [25:22] dir, [48:26] thr
	logic        s_tuser;  // [0] operation
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;  // [4:0] x, [9:5] y, [14:10] z, [37:15] dE, [50:38] count
	logic [2:0]  m_tuser;  // [2:0] status
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	int fail_count, pending, placed;
	int idle_cycles;
	int results_taken;
	bit send_burst, take_burst;

	lattice_metropolis_particle_mover u_dut (.*);

	lmpm_result_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random result gaps, and one long hold-off so the block backs up into its input.
	initial begin
		m_tready = 1'b0;
		results_taken = 0;
		@(posedge clk iff arst_n);
		forever begin
			int gap;
			if (results_taken == 150) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (results_taken % 40 == 0)
				take_burst = ($urandom_range(0, 3) == 0);
			gap = take_burst ? 0 : int'($urandom_range(0, 8));
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_taken++;
		end
	end

	// Count cycles with no transfer on any channel; give up at the limit.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_request(input logic op, input int x, input int y, input int idx,
			input int dir, input int thr);
		int gap;
		gap = send_burst ? 0 : int'($urandom_range(0, 8));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, thr[22:0], dir[3:0], idx[11:0], y[4:0], x[4:0]};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drop_at(input int x, input int y);
		send_request(lmpm_pkg::OP_DROP, x, y, $urandom, $urandom, $urandom);
	endtask

	task automatic move_particle(input int idx, input int dir, input int thr);
		send_request(lmpm_pkg::OP_MOVE, $urandom, $urandom, idx, dir, thr);
	endtask

	// Drain every outstanding result, then let the block settle before config writes.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[15:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_energies(input int ee, input int ef, input int fe, input int ff,
			input int sub);
		write_reg(lmpm_pkg::CFG_EE, ee);
		write_reg(lmpm_pkg::CFG_EF, ef);
		write_reg(lmpm_pkg::CFG_FE, fe);
		write_reg(lmpm_pkg::CFG_FF, ff);
		write_reg(lmpm_pkg::CFG_SUB, sub);
	endtask

	function automatic int pick_threshold();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return -4194304;
			2: return -int'($urandom_range(0, 4096));
			default: return -int'($urandom_range(0, 4194304));
		endcase
	endfunction

	task automatic random_requests(input int n);
		int kind;
		for (int i = 0; i < n; i++) begin
			if (i % 30 == 0)
				send_burst = ($urandom_range(0, 3) == 0);
			kind = int'($urandom_range(0, 99));
			if (kind < 25)
				drop_at($urandom_range(0, 31), $urandom_range(0, 31));
			else if (kind < 94 && placed > 0)
				move_particle($urandom_range(0, placed - 1), $urandom_range(0, 11),
					pick_threshold());
			else
				// noise: any index and direction, most of them out of range
				move_particle($urandom_range(0, 4095), $urandom_range(0, 15),
					pick_threshold());
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tuser   = lmpm_pkg::OP_DROP;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = lmpm_pkg::CFG_EE;
		cfg_data  = '0;
		idle_cycles = 0;
		send_burst = 1'b0;
		take_burst = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: mild attraction, then corners, a full column, the z bounds.
		load_energies(16'sh0100, -16'sh0080, 16'sh0040, -16'sh0200, -16'sh0300);
		move_particle(0, 0, 0);            // nothing placed yet: bad index
		drop_at(0, 0);
		drop_at(31, 31);
		drop_at(31, 0);
		move_particle(0, 8, 0);            // layer 1 moving down: out of bounds
		move_particle(0, 0, -4194304);     // steps x from 0 to 1
		move_particle(1, 12, 0);           // direction past the table
		move_particle(1, 15, 0);
		move_particle(4095, 3, 0);         // index far past the count
		for (int i = 0; i < 30; i++)
			drop_at(5, 7);                 // stack the column up to the start layer
		drop_at(5, 7);                     // start site taken: blocked
		move_particle(4, 4, -4194304);     // up into the stack: occupied
		move_particle(32, 4, -4194304);    // top of the stack climbs to layer 31
		move_particle(32, 7, -4194304);    // from layer 31 upward: out of bounds
		move_particle(5, 1, 0);
		move_particle(3, 2, -4194304);
		drain();

		// Extremes of the energy registers, then a few random settings.
		load_energies(32767, -32768, 32767, -32768, 32767);
		random_requests(260);
		drain();
		load_energies(-32768, 32767, -32768, 32767, -32768);
		random_requests(260);
		drain();
		for (int k = 0; k < 3; k++) begin
			load_energies($urandom, $urandom, $urandom, $urandom, $urandom);
			random_requests(260);
			drain();
		end

		// Cleared energies: a few more drops and moves to finish.
		load_energies(0, 0, 0, 0, 0);
		for (int i = 0; i < 10; i++)
			drop_at($urandom_range(0, 31), $urandom_range(0, 31));
		random_requests(40);
		drain();

		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ lattice_metropolis_particle_mover.f @@
hdl/lmpm_pkg.sv
hdl/lmpm_nb_gen.sv
hdl/lattice_metropolis_particle_mover.sv
hdl/lmpm_checker.sv
sim/lmpm_result_checker.sv
sim/lattice_metropolis_particle_mover_tb.sv
